// ----- rtl/fhm_pkg.sv -----
// Shared definitions for the mutex with a first-in first-out wait queue.
// Holds the queue depth, the derived widths, the request and status codes and the ring port struct.
// Depends on nothing; every other file imports it.
`default_nettype none

package fhm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TID_W       = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;

    localparam logic [KIND_W-1:0] KIND_LOCK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRYLOCK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOCK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FREE_UNLOCK = 3'd5;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [TID_W-1:0] tid_t;

    typedef struct packed {
        logic wr_en;
        ptr_t wr_addr;
        logic rd_en;
        ptr_t rd_addr;
    } fhm_ring_req_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fhm_ring.sv -----
// Wait-queue storage: a synchronous memory of thread ids with one write and one read port.
// The read data is registered and appears in the cycle after the read request.
// Depends on fhm_pkg.
`default_nettype none

module fhm_ring (
    input  wire logic                  clk,
    input  wire fhm_pkg::fhm_ring_req_t req,
    input  wire fhm_pkg::tid_t          wr_data,
    output fhm_pkg::tid_t               rd_data
);
    import fhm_pkg::*;

    tid_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fifo_handoff_mutex.sv -----
// Top level of the mutex with a first-in first-out wait queue and direct hand-off on unlock.
// Holds the owner, user count and ring pointers, and the output register; the queue is in fhm_ring.
// Depends on fhm_pkg and fhm_ring.
//
//  Channel  Direction  tdata                                        tuser
//  s_*      in         [15:0] thread_id                             [1:0] kind
//  m_*      out        [15:0] owner_id, [16] woken_valid,           [2:0] status
//                      [32:17] woken_id, [39:33] zero
//
// A request loads its result into the output register when it is taken; an unlock that wakes a waiter
// first reads the head entry from the ring memory, whose read data is registered, and loads it from the wake state.
// Reset clears the owner, user count, pointers and the control state; the ring
// is not cleared, as an entry is only read after it has been written.
// A new beat is taken while a finished result is being taken in the same cycle.
`default_nettype none

module fifo_handoff_mutex (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [15:0] thread_id
    input  wire logic [1:0]  s_tuser,  // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // [15:0] owner_id, [16] woken_valid, [32:17] woken_id
    output logic [2:0]       m_tuser   // [2:0] status
);
    import fhm_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAKE = 1'b1;

    logic              state_reg, state_next;
    tid_t              owner_reg, owner_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    ptr_t              head_reg, head_next;
    ptr_t              tail_reg, tail_next;
    logic              out_valid_reg, out_valid_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    tid_t                owner_out_reg, owner_out_next;
    logic                woken_valid_reg, woken_valid_next;
    tid_t                woken_id_reg, woken_id_next;
    logic                load;

    fhm_ring_req_t ring_req;
    tid_t          ring_rd_data;

    logic        accept;
    logic        ring_empty;
    logic        ring_full;
    tid_t        tid;
    logic [KIND_W-1:0] kind;

    assign tid        = s_tdata;
    assign kind       = s_tuser;
    assign s_tready   = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign ring_empty = (head_reg == tail_reg);
    assign ring_full  = (ring_next(tail_reg) == head_reg);

    fhm_ring u_ring (
        .clk     (clk),
        .req     (ring_req),
        .wr_data (tid),
        .rd_data (ring_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        owner_next       = owner_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        status_next      = status_reg;
        owner_out_next   = owner_out_reg;
        woken_valid_next = 1'b0;
        woken_id_next    = '0;
        load             = 1'b0;
        ring_req.wr_en   = 1'b0;
        ring_req.wr_addr = tail_reg;
        ring_req.rd_en   = 1'b0;
        ring_req.rd_addr = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (kind)
                        KIND_LOCK:
                        begin
                            if (tid == '0)
                            begin
                                status_next = ST_BUSY;
                            end
                            else if (owner_reg == '0)
                            begin
                                owner_next  = tid;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_GRANTED;
                            end
                            else if (ring_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ring_req.wr_en = 1'b1;
                                tail_next      = ring_next(tail_reg);
                                count_next     = count_reg + CNT_W'(1);
                                status_next    = ST_QUEUED;
                            end
                        end
                        KIND_TRYLOCK:
                        begin
                            if (tid != '0 && owner_reg == '0)
                            begin
                                owner_next  = tid;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_GRANTED;
                            end
                            else
                            begin
                                status_next = ST_BUSY;
                            end
                        end
                        KIND_UNLOCK:
                        begin
                            if (owner_reg == '0)
                            begin
                                status_next = ST_FREE_UNLOCK;
                            end
                            else if (!ring_empty)
                            begin
                                ring_req.rd_en = 1'b1;
                                head_next      = ring_next(head_reg);
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                                load       = 1'b0;
                                state_next = S_WAKE;
                            end
                            else
                            begin
                                owner_next  = '0;
                                count_next  = '0;
                                status_next = ST_OK;
                            end
                        end
                        default:
                        begin
                            status_next = (count_reg == '0) ? ST_OK : ST_BUSY;
                        end
                    endcase
                    owner_out_next = owner_next;
                end
            end
            S_WAKE:
            begin
                load             = 1'b1;
                owner_next       = ring_rd_data;
                owner_out_next   = ring_rd_data;
                status_next      = ST_OK;
                woken_valid_next = 1'b1;
                woken_id_next    = ring_rd_data;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            owner_reg     <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            owner_reg     <= owner_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg      <= status_next;
            owner_out_reg   <= owner_out_next;
            woken_valid_reg <= woken_valid_next;
            woken_id_reg    <= woken_id_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, woken_id_reg, woken_valid_reg, owner_out_reg};

endmodule

`default_nettype wire

// ----- dv/fhm_checker.sv -----
// Checker for fifo_handoff_mutex: watches both stream channels, keeps its own model of the
// mutex and its wait ring, and compares every reply beat field by field with its prediction.
// Depends on fhm_pkg for the widths, request kinds and status codes.

module fhm_checker
    import fhm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] thread_id
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [15:0] owner_id, [16] woken_valid, [32:17] woken_id
    input  logic [2:0]  m_tuser,   // [2:0] status
    output int          fail_count,
    output int          pending,
    output int          requests_seen,
    output int          replies_seen,
    output int          full_seen,
    output int          handoffs_seen
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        tid_t                owner_id;
        logic                woken_valid;
        tid_t                woken_id;
    } mutex_reply_t;

    tid_t         holder;
    logic [4:0]   users;
    tid_t         waiters [QUEUE_DEPTH];
    ptr_t         head_ptr;
    ptr_t         tail_ptr;
    mutex_reply_t awaited_replies [$];

    int failures = 0;
    int requests = 0;
    int replies = 0;
    int fulls = 0;
    int handoffs = 0;

    function automatic ptr_t step_ptr(input ptr_t p);
        return ptr_t'((int'(p) + 1) % QUEUE_DEPTH);
    endfunction

    function automatic mutex_reply_t predict_mutex_reply(input logic [1:0] kind, input tid_t tid);
        mutex_reply_t r;
        r = '0;
        r.status = ST_OK;
        case (kind)
            KIND_LOCK:
            begin
                if (tid == '0)
                begin
                    r.status = ST_BUSY;
                end
                else if (holder == '0)
                begin
                    holder = tid;
                    users = users + 5'd1;
                    r.status = ST_GRANTED;
                end
                else if (step_ptr(tail_ptr) == head_ptr)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    waiters[tail_ptr] = tid;
                    tail_ptr = step_ptr(tail_ptr);
                    users = users + 5'd1;
                    r.status = ST_QUEUED;
                end
            end
            KIND_TRYLOCK:
            begin
                if (tid != '0 && holder == '0)
                begin
                    holder = tid;
                    users = users + 5'd1;
                    r.status = ST_GRANTED;
                end
                else
                begin
                    r.status = ST_BUSY;
                end
            end
            KIND_UNLOCK:
            begin
                if (holder == '0)
                begin
                    r.status = ST_FREE_UNLOCK;
                end
                else
                begin
                    if (users != '0)
                    begin
                        users = users - 5'd1;
                    end
                    if (head_ptr != tail_ptr)
                    begin
                        r.woken_id = waiters[head_ptr];
                        r.woken_valid = 1'b1;
                        head_ptr = step_ptr(head_ptr);
                        holder = r.woken_id;
                    end
                    else
                    begin
                        holder = '0;
                        users = '0;
                    end
                    r.status = ST_OK;
                end
            end
            default:
            begin
                r.status = (users == '0) ? ST_OK : ST_BUSY;
            end
        endcase
        r.owner_id = holder;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("reply %0d: %s expected %0h, got %0h", replies, field, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        mutex_reply_t want;
        if (!rst_n)
        begin
            holder = '0;
            users = '0;
            head_ptr = '0;
            tail_ptr = '0;
            awaited_replies.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies++;
                if (awaited_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("reply %0d arrived with no request outstanding", replies);
                    end
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    check_field("status", 16'(want.status), 16'(m_tuser));
                    check_field("owner_id", want.owner_id, m_tdata[15:0]);
                    check_field("woken_valid", 16'(want.woken_valid), 16'(m_tdata[16]));
                    check_field("woken_id", want.woken_id, m_tdata[32:17]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                requests++;
                want = predict_mutex_reply(s_tuser, s_tdata);
                if (want.status == ST_FULL)
                begin
                    fulls++;
                end
                if (want.woken_valid)
                begin
                    handoffs++;
                end
                awaited_replies.push_back(want);
            end
        end
        fail_count    <= failures;
        pending       <= awaited_replies.size();
        requests_seen <= requests;
        replies_seen  <= replies;
        full_seen     <= fulls;
        handoffs_seen <= handoffs;
    end

endmodule

// ----- dv/tb_fifo_handoff_mutex.sv -----
// Testbench top for fifo_handoff_mutex: drives request beats with random gaps and reply stalls,
// directed corner cases first and then biased random traffic, and gives the verdict.
// Depends on fhm_pkg, the block itself and fhm_checker, which does all prediction and comparison.

module tb_fifo_handoff_mutex;
    import fhm_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BEATS = 1725;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = KIND_LOCK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    int fail_count;
    int pending;
    int requests_seen;
    int replies_seen;
    int full_seen;
    int handoffs_seen;
    int idle_cycles = 0;
    int max_gap = 6;

    fifo_handoff_mutex dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fhm_checker reply_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .replies_seen  (replies_seen),
        .full_seen     (full_seen),
        .handoffs_seen (handoffs_seen)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic send_request(input logic [1:0] kind, input tid_t tid);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= tid;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, max_gap);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no beat accepted for %0d cycles, giving up", IDLE_LIMIT);
            $display("[fifo_handoff_mutex] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int   mode;
        int   lock_pct;
        int   unlock_pct;
        int   r;
        logic [1:0] kind;
        tid_t tid;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Idle checks on a fresh mutex, zero-id rejections, then fill the ring to overflow.
        send_request(KIND_DESTROY, 16'h1234);
        send_request(KIND_UNLOCK, 16'h0042);
        send_request(KIND_LOCK, 16'h0000);
        send_request(KIND_TRYLOCK, 16'h0000);
        send_request(KIND_TRYLOCK, 16'hFFFF);
        send_request(KIND_TRYLOCK, 16'h0001);
        send_request(KIND_DESTROY, 16'h0000);
        send_request(KIND_LOCK, 16'hFFFF);
        for (int i = 0; i < 14; i++)
        begin
            send_request(KIND_LOCK, tid_t'(1) << i);
        end
        send_request(KIND_LOCK, 16'h7FFF);
        send_request(KIND_UNLOCK, 16'hBEEF);
        send_request(KIND_DESTROY, 16'h5555);

        mode = 2;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 40 == 0)
            begin
                mode = $urandom_range(0, 2);
                max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            end
            case (mode)
                0:
                begin
                    lock_pct = 60;
                    unlock_pct = 20;
                end
                1:
                begin
                    lock_pct = 15;
                    unlock_pct = 65;
                end
                default:
                begin
                    lock_pct = 35;
                    unlock_pct = 35;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < lock_pct)
            begin
                kind = KIND_LOCK;
            end
            else if (r < lock_pct + unlock_pct)
            begin
                kind = KIND_UNLOCK;
            end
            else if (r < lock_pct + unlock_pct + 10)
            begin
                kind = KIND_TRYLOCK;
            end
            else
            begin
                kind = KIND_DESTROY;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                tid = '0;
            end
            else if (r < 40)
            begin
                tid = tid_t'($urandom_range(1, 8));
            end
            else
            begin
                tid = tid_t'($urandom_range(1, 65535));
            end
            send_request(kind, tid);
        end
        s_tvalid <= 1'b0;

        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (8) @(posedge clk);

        $display("%0d requests sent and %0d replies checked;", requests_seen, replies_seen);
        $display("%0d lock attempts met a full ring and %0d unlocks handed over to a waiter.",
                 full_seen, handoffs_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[fifo_handoff_mutex] OK");
        end
        else
        begin
            $display("[fifo_handoff_mutex] ERROR");
        end
        $finish;
    end

endmodule
